// ----- sv/lzwd_pkg.sv -----
package lzwd_pkg;

    // dictionary and string limits
    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_STRING    = 64;
    localparam int SINGLE_CODES  = 256;

    // field and index widths
    localparam int CODE_IN_W = 16;
    localparam int BYTE_W    = 8;
    localparam int CODE_W    = $clog2(TABLE_ENTRIES);
    localparam int FREE_W    = CODE_W + 1;
    localparam int STK_W     = $clog2(MAX_STRING);
    localparam int LEN_W     = STK_W + 1;
    localparam int CMP_W     = (FREE_W > CODE_IN_W) ? FREE_W : CODE_IN_W;

    // one dictionary entry as held in the table memory
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] head;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

// ----- sv/lzwd_ram.sv -----
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/lzw_code_decoder_unit.sv -----
// LZW code decoder: one code per item in, the bytes of its string out, last byte marked.
// Steps for a table code of n bytes: lookup, n - 1 chain steps, stack read, output load; a code
// equal to the next free code skips the lookup; a single-byte code only has the stack read and
// output load. The prefix walk reads the table memory once per cycle, the reversal stack gives
// one byte per cycle while byte_stall is low, and a new code is taken only back in idle.
// Reset clears the free-code counter to 256 and forgets the previous code; memories keep contents.
module lzw_code_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           code_valid,
    output logic                           code_stall,
    input  logic [lzwd_pkg::CODE_IN_W-1:0] code,
    output logic                           byte_valid,
    input  logic                           byte_stall,
    output logic [lzwd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           last,
    output logic                           error
);

    import lzwd_pkg::*;

    // control state
    state_t            state_reg, state_next;
    logic [FREE_W-1:0] next_free_reg, next_free_next;
    logic              prior_valid_reg, prior_valid_next;
    logic [CODE_W-1:0] prior_code_reg, prior_code_next;
    logic [LEN_W-1:0]  prior_len_reg, prior_len_next;
    logic [BYTE_W-1:0] prior_head_reg, prior_head_next;
    logic              out_valid_reg, out_valid_next;
    logic              rd_valid_reg, rd_valid_next;

    // walk and read-out state
    logic [CODE_W-1:0] cur_reg, cur_next;
    logic [STK_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  issue_reg, issue_next;
    logic              rd_last_reg, rd_last_next;

    // output payload
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    // memory ports
    logic              tbl_we;
    logic [CODE_W-1:0] tbl_waddr;
    entry_t            tbl_wdata;
    logic [CODE_W-1:0] tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;
    entry_t            rd_entry;
    logic              stk_we;
    logic [STK_W-1:0]  stk_waddr;
    logic [BYTE_W-1:0] stk_wdata;
    logic              stk_re;
    logic [STK_W-1:0]  stk_raddr;
    logic [BYTE_W-1:0] stk_rdata;

    // decode of the incoming code
    logic [CMP_W-1:0]  code_cmp;
    logic [CMP_W-1:0]  free_cmp;
    logic              is_lit;
    logic              is_new;
    logic              can_add;
    logic              code_err;
    logic [LEN_W-1:0]  grown_len;
    logic              load_out;
    logic              err_load;

    assign rd_entry  = entry_t'(tbl_rdata);
    assign code_cmp  = CMP_W'(code);
    assign free_cmp  = CMP_W'(next_free_reg);
    assign is_lit    = code_cmp < CMP_W'(SINGLE_CODES);
    assign is_new    = prior_valid_reg && (code_cmp == free_cmp);
    assign can_add   = (next_free_reg < FREE_W'(TABLE_ENTRIES)) &&
                       (prior_len_reg < LEN_W'(MAX_STRING));
    assign grown_len = prior_len_reg + LEN_W'(1);
    assign code_err  = !prior_valid_reg ? !is_lit :
                       ((code_cmp > free_cmp) || (is_new && !can_add));

    assign code_stall = (state_reg != ST_IDLE);
    assign byte_valid = out_valid_reg;
    assign data_byte  = byte_reg;
    assign last       = last_reg;
    assign error      = error_reg;

    // stack byte moves into the output register when that is free
    assign load_out = rd_valid_reg && (!out_valid_reg || !byte_stall);

    // dictionary: prefix, suffix, length and first byte per code
    lzwd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (1'b1),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    // reversal stack for the bytes of one string
    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_STRING)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        next_free_next   = next_free_reg;
        prior_valid_next = prior_valid_reg;
        prior_code_next  = prior_code_reg;
        prior_len_next   = prior_len_reg;
        prior_head_next  = prior_head_reg;
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        issue_next       = issue_reg;
        rd_valid_next    = rd_valid_reg;
        rd_last_next     = rd_last_reg;
        err_load         = 1'b0;

        tbl_we           = 1'b0;
        tbl_waddr        = next_free_reg[CODE_W-1:0];
        tbl_wdata.prefix = prior_code_reg;
        tbl_wdata.suffix = prior_head_reg;
        tbl_wdata.len    = grown_len;
        tbl_wdata.head   = prior_head_reg;
        tbl_raddr        = cur_reg;
        stk_we           = 1'b0;
        stk_waddr        = idx_reg;
        stk_wdata        = cur_reg[BYTE_W-1:0];
        stk_re           = 1'b0;
        stk_raddr        = issue_reg[STK_W-1:0];

        if (load_out)
        begin
            rd_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (code_valid)
                begin
                    if (code_err)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (is_lit)
                    begin
                        // single byte: one stack entry, entry gets this byte as tail
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = code[BYTE_W-1:0];
                        if (prior_valid_reg && can_add)
                        begin
                            tbl_we           = 1'b1;
                            tbl_wdata.suffix = code[BYTE_W-1:0];
                            next_free_next   = next_free_reg + FREE_W'(1);
                        end
                        prior_valid_next = 1'b1;
                        prior_code_next  = code[CODE_W-1:0];
                        prior_len_next   = LEN_W'(1);
                        prior_head_next  = code[BYTE_W-1:0];
                        n_next           = LEN_W'(1);
                        issue_next       = '0;
                        state_next       = ST_EMIT;
                    end
                    else if (is_new)
                    begin
                        // code not yet known: previous string plus its own first byte
                        tbl_we         = 1'b1;
                        next_free_next = next_free_reg + FREE_W'(1);
                        stk_we         = 1'b1;
                        stk_waddr      = prior_len_reg[STK_W-1:0];
                        stk_wdata      = prior_head_reg;
                        tbl_raddr      = prior_code_reg;
                        cur_next       = prior_code_reg;
                        idx_next       = STK_W'(prior_len_reg - LEN_W'(1));
                        n_next         = grown_len;
                        prior_code_next = code[CODE_W-1:0];
                        prior_len_next  = grown_len;
                        state_next      = ST_WALK;
                    end
                    else
                    begin
                        tbl_raddr  = code[CODE_W-1:0];
                        cur_next   = code[CODE_W-1:0];
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                // entry of the code itself: last byte, length, first byte
                stk_we    = 1'b1;
                stk_waddr = STK_W'(rd_entry.len - LEN_W'(1));
                stk_wdata = rd_entry.suffix;
                tbl_raddr = rd_entry.prefix;
                cur_next  = rd_entry.prefix;
                idx_next  = STK_W'(rd_entry.len - LEN_W'(2));
                n_next    = rd_entry.len;
                if (can_add)
                begin
                    tbl_we           = 1'b1;
                    tbl_wdata.suffix = rd_entry.head;
                    next_free_next   = next_free_reg + FREE_W'(1);
                end
                prior_code_next = cur_reg;
                prior_len_next  = rd_entry.len;
                prior_head_next = rd_entry.head;
                state_next      = ST_WALK;
            end

            ST_WALK:
            begin
                // one chain step per cycle, stack filled from the top down
                stk_we = 1'b1;
                if (cur_reg < CODE_W'(SINGLE_CODES))
                begin
                    stk_wdata  = cur_reg[BYTE_W-1:0];
                    issue_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    stk_wdata = rd_entry.suffix;
                    tbl_raddr = rd_entry.prefix;
                    cur_next  = rd_entry.prefix;
                    idx_next  = idx_reg - STK_W'(1);
                end
            end

            ST_EMIT:
            begin
                // read the stack in order, one byte ahead of the output register
                if ((issue_reg != n_reg) && (!rd_valid_reg || load_out))
                begin
                    stk_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = (issue_reg + LEN_W'(1)) == n_reg;
                    issue_next    = issue_reg + LEN_W'(1);
                end
                if ((issue_reg == n_reg) && !rd_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ERR:
            begin
                if (!out_valid_reg || !byte_stall)
                begin
                    err_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            byte_next      = stk_rdata;
            last_next      = rd_last_reg;
            error_next     = 1'b0;
        end
        else if (err_load)
        begin
            out_valid_next = 1'b1;
            byte_next      = '0;
            last_next      = 1'b1;
            error_next     = 1'b1;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            next_free_reg   <= FREE_W'(SINGLE_CODES);
            prior_valid_reg <= 1'b0;
            prior_code_reg  <= '0;
            prior_len_reg   <= LEN_W'(1);
            out_valid_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_free_reg   <= next_free_next;
            prior_valid_reg <= prior_valid_next;
            prior_code_reg  <= prior_code_next;
            prior_len_reg   <= prior_len_next;
            out_valid_reg   <= out_valid_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prior_head_reg <= prior_head_next;
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        issue_reg      <= issue_next;
        rd_last_reg    <= rd_last_next;
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        error_reg      <= error_next;
    end

endmodule
